// ===== sv/mktd_pkg.sv =====
package mktd_pkg;

   // default sizes, handed down from the top level
   localparam int MAX_SYMBOLS_DEF = 4;
   localparam int TIMER_BITS_DEF = 16;

   // configuration port
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DASH_THRESHOLD = 2'd0,
      CSR_LETTER_GAP     = 2'd1,
      CSR_PRESS_FLOOR    = 2'd2
   } mktd_csr_index_type;

   localparam logic [CSR_DATA_BITS-1:0] DASH_THRESHOLD_RESET = 16'd600;
   localparam logic [CSR_DATA_BITS-1:0] LETTER_GAP_RESET = 16'd2000;
   localparam logic [CSR_DATA_BITS-1:0] PRESS_FLOOR_RESET = 16'd25;

   // letter decode: at most four symbols, ternary hash below 81
   localparam int DECODE_SYMBOLS = 4;
   localparam int DECODE_LEN_BITS = 3;
   localparam int HASH_BITS = 7;
   localparam int LETTER_BITS = 5;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] dash_threshold;
      logic [CSR_DATA_BITS-1:0] letter_gap;
      logic [CSR_DATA_BITS-1:0] press_floor;
   } mktd_cfg_type;

   typedef struct packed {
      logic                   key_lamp;
      logic                   symbol_done;
      logic                   symbol_dash;
      logic                   letter_done;
      logic [LETTER_BITS-1:0] letter_index;
      logic                   letter_rejected;
   } mktd_result_type;

   typedef struct packed {
      logic                   hit;
      logic [LETTER_BITS-1:0] index;
   } mktd_letter_type;

   // ternary hash of a pattern to a letter, A is index 0
   function automatic mktd_letter_type letter_of_hash(input logic [HASH_BITS-1:0] h);
      mktd_letter_type l;
      l.hit = 1'b1;
      unique case (h)
         7'd1:    l.index = 5'd4;
         7'd2:    l.index = 5'd19;
         7'd4:    l.index = 5'd8;
         7'd5:    l.index = 5'd0;
         7'd7:    l.index = 5'd13;
         7'd8:    l.index = 5'd12;
         7'd13:   l.index = 5'd18;
         7'd14:   l.index = 5'd20;
         7'd16:   l.index = 5'd17;
         7'd17:   l.index = 5'd22;
         7'd22:   l.index = 5'd3;
         7'd23:   l.index = 5'd10;
         7'd25:   l.index = 5'd6;
         7'd26:   l.index = 5'd14;
         7'd40:   l.index = 5'd7;
         7'd41:   l.index = 5'd21;
         7'd43:   l.index = 5'd5;
         7'd49:   l.index = 5'd11;
         7'd52:   l.index = 5'd15;
         7'd53:   l.index = 5'd9;
         7'd67:   l.index = 5'd1;
         7'd68:   l.index = 5'd23;
         7'd70:   l.index = 5'd2;
         7'd71:   l.index = 5'd24;
         7'd76:   l.index = 5'd25;
         7'd77:   l.index = 5'd16;
         default: begin
            l.hit = 1'b0;
            l.index = '0;
         end
      endcase
      return l;
   endfunction

   // fold the pattern, first symbol first, dot adds 1 and dash adds 2
   function automatic mktd_letter_type decode_pattern(
      input logic [DECODE_SYMBOLS-1:0]  bits,
      input logic [DECODE_LEN_BITS-1:0] len
   );
      logic [HASH_BITS-1:0] h;
      mktd_letter_type      l;
      h = '0;
      for (int i = DECODE_SYMBOLS - 1; i >= 0; i--) begin
         if (DECODE_LEN_BITS'(i) < len) begin
            h = HASH_BITS'(h * HASH_BITS'(3) + HASH_BITS'(1) + HASH_BITS'(bits[i]));
         end
      end
      l = letter_of_hash(h);
      if (len == '0 || len > DECODE_LEN_BITS'(DECODE_SYMBOLS)) begin
         l.hit = 1'b0;
         l.index = '0;
      end
      return l;
   endfunction

endpackage

// ===== sv/mktd_csr.sv =====
module mktd_csr
   import mktd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      write_enable,
   input  logic [CSR_INDEX_BITS-1:0] index,
   input  logic [CSR_DATA_BITS-1:0]  write_data,
   output mktd_cfg_type              cfg
);

   mktd_cfg_type cfg_ff, cfg_in;

   // register decode, unused index is dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (write_enable) begin
         unique case (index)
            CSR_DASH_THRESHOLD: cfg_in.dash_threshold = write_data;
            CSR_LETTER_GAP:     cfg_in.letter_gap = write_data;
            CSR_PRESS_FLOOR:    cfg_in.press_floor = write_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dash_threshold <= DASH_THRESHOLD_RESET;
         cfg_ff.letter_gap <= LETTER_GAP_RESET;
         cfg_ff.press_floor <= PRESS_FLOOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/mktd_tick.sv =====
module mktd_tick
   import mktd_pkg::*;
#(
   parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
   parameter int TIMER_BITS = TIMER_BITS_DEF
)(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic            key_down,
   input  logic            decode_enable,
   input  mktd_cfg_type    cfg,
   output mktd_result_type result
);

   localparam int LEN_BITS = $clog2(MAX_SYMBOLS + 2);
   localparam int CMP_BITS = (TIMER_BITS > CSR_DATA_BITS) ? TIMER_BITS : CSR_DATA_BITS;

   logic                   held_ff, held_in;
   logic                   pending_ff, pending_in;
   logic [TIMER_BITS-1:0]  press_ff, press_in;
   logic [TIMER_BITS-1:0]  gap_ff, gap_in;
   logic [MAX_SYMBOLS-1:0] bits_ff, bits_in;
   logic [LEN_BITS-1:0]    len_ff, len_in;
   logic                   dash;
   mktd_letter_type        letter;

   // per-tick timing, symbol and letter logic
   always_comb begin
      held_in = held_ff;
      pending_in = pending_ff;
      press_in = press_ff;
      gap_in = gap_ff;
      bits_in = bits_ff;
      len_in = len_ff;
      dash = 1'b0;
      letter = '0;
      result = '0;

      if (!decode_enable) begin
         held_in = 1'b0;
         pending_in = 1'b0;
         press_in = '0;
         gap_in = '0;
         bits_in = '0;
         len_in = '0;
      end else begin
         // saturating timers
         if (held_ff && press_ff != '1) begin
            press_in = press_ff + TIMER_BITS'(1);
         end
         if (pending_ff && gap_ff != '1) begin
            gap_in = gap_ff + TIMER_BITS'(1);
         end

         // key edges
         if (key_down && !held_ff) begin
            held_in = 1'b1;
            press_in = '0;
         end else if (!key_down && held_ff) begin
            held_in = 1'b0;
            if (CMP_BITS'(press_in) >= CMP_BITS'(cfg.press_floor)) begin
               dash = CMP_BITS'(press_in) >= CMP_BITS'(cfg.dash_threshold);
               result.symbol_done = 1'b1;
               result.symbol_dash = dash;
               if (len_ff < LEN_BITS'(MAX_SYMBOLS)) begin
                  bits_in = {bits_ff[MAX_SYMBOLS-2:0], dash};
                  len_in = len_ff + LEN_BITS'(1);
               end else begin
                  len_in = LEN_BITS'(MAX_SYMBOLS + 1);
               end
               pending_in = 1'b1;
               gap_in = '0;
            end
         end

         // letter gap elapsed
         if (pending_in && !held_in && CMP_BITS'(gap_in) >= CMP_BITS'(cfg.letter_gap)) begin
            if (len_in <= LEN_BITS'(DECODE_SYMBOLS)) begin
               letter = decode_pattern(bits_in[DECODE_SYMBOLS-1:0],
                                       DECODE_LEN_BITS'(len_in));
            end
            result.letter_done = letter.hit;
            result.letter_index = letter.index;
            result.letter_rejected = !letter.hit;
            pending_in = 1'b0;
            bits_in = '0;
            len_in = '0;
            gap_in = '0;
         end
      end
      result.key_lamp = held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
         pending_ff <= 1'b0;
         press_ff <= '0;
         gap_ff <= '0;
         bits_ff <= '0;
         len_ff <= '0;
      end else if (accept) begin
         held_ff <= held_in;
         pending_ff <= pending_in;
         press_ff <= press_in;
         gap_ff <= gap_in;
         bits_ff <= bits_in;
         len_ff <= len_in;
      end
   end

endmodule

// ===== sv/mktd_out_buf.sv =====
module mktd_out_buf
   import mktd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  mktd_result_type push_data,
   output logic            full,
   output logic            out_valid,
   input  logic            out_stall,
   output mktd_result_type out_data
);

   logic            main_valid_ff, main_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   mktd_result_type main_data_ff, main_data_in;
   mktd_result_type skid_data_ff, skid_data_in;
   logic            pop;

   assign pop = main_valid_ff && !out_stall;

   // output register with one skid entry behind it
   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in = skid_data_ff;
      if (!main_valid_ff || pop) begin
         main_valid_in = skid_valid_ff || push;
         main_data_in = skid_valid_ff ? skid_data_ff : push_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data = main_data_ff;

endmodule

// ===== sv/morse_key_timing_decoder_unit.sv =====
// Morse key timing decoder: one item per millisecond tick of a telegraph key.
// req channel: req_key_down is the key level this tick, req_decode_enable
// lets decoding run (low drops the partial letter and gives an all-zero item).
// rsp channel: one item per req item, in order: key lamp, an accepted dot or
// dash, a decoded letter (0 is A) or a rejected pattern.
// csr port: csr_index 0 dash threshold, 1 letter gap, 2 minimum press, all in
// ticks; written with csr_write_enable; the user must write only while the block
// is idle, which the block does not enforce. Output: the rsp item is registered in
// the output register, or in the skid entry under rsp_stall. Throughput: one req
// item per cycle while req_stall is low; the tick's timer update, symbol
// classification and letter lookup run in one pass from key state to output register.
// Stall: a result held by rsp_stall sits in the output register while one
// more item goes to a skid entry; req_stall rises only when both are full.
// Reset: timers, pattern and output are cleared, the registers return to
// 600, 2000 and 25 ticks; no clearing pass, items are taken the next cycle.
module morse_key_timing_decoder_unit
   import mktd_pkg::*;
#(
   parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
   parameter int TIMER_BITS = TIMER_BITS_DEF
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_key_down,
   input  logic                      req_decode_enable,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_key_lamp,
   output logic                      rsp_symbol_done,
   output logic                      rsp_symbol_dash,
   output logic                      rsp_letter_done,
   output logic [LETTER_BITS-1:0]    rsp_letter_index,
   output logic                      rsp_letter_rejected,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   mktd_cfg_type    cfg;
   mktd_result_type tick_result;
   mktd_result_type out_data;
   logic            accept;
   logic            full;

   assign accept = req_valid && !full;
   assign req_stall = full;

   // configuration registers
   mktd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .write_enable (csr_write_enable),
      .index        (csr_index),
      .write_data   (csr_write_data),
      .cfg          (cfg)
   );

   // key timing and letter decode
   mktd_tick #(
      .MAX_SYMBOLS (MAX_SYMBOLS),
      .TIMER_BITS  (TIMER_BITS)
   ) u_tick (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .key_down      (req_key_down),
      .decode_enable (req_decode_enable),
      .cfg           (cfg),
      .result        (tick_result)
   );

   // result register and skid entry
   mktd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (tick_result),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_key_lamp = out_data.key_lamp;
   assign rsp_symbol_done = out_data.symbol_done;
   assign rsp_symbol_dash = out_data.symbol_dash;
   assign rsp_letter_done = out_data.letter_done;
   assign rsp_letter_index = out_data.letter_index;
   assign rsp_letter_rejected = out_data.letter_rejected;

endmodule

// ===== sv/mktd_checker.sv =====
module mktd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_symbol_done,
   input logic rsp_symbol_dash
);

   // after an accepted item the output is always valid in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted item did not reach the output");

   // input side only backs up behind a stalled output
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("req_stall rose without a stalled output");

   // nothing is shown right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("output valid right after reset");

   // a dash flag comes only with an accepted symbol
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_symbol_dash) |-> rsp_symbol_done)
      else $error("dash flagged without a symbol");

endmodule

bind morse_key_timing_decoder_unit mktd_checker u_mktd_checker (.*);
